// File: design/rrpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrpg_pkg;

  localparam int VTX_W            = 7;   // vertex index / round number
  localparam int NUM_W            = 8;   // vertex count register
  localparam int CNT_W            = 6;   // pairs left in a round, minus one
  localparam int MAX_VERTICES_DEF = 128;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture a round and set up the first pair
    logic push;   // move the current pair into the output register, advance
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // current pair is the final one of the round
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/rrpg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rrpg_ctrl import rrpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.push = (state == S_RUN) && slot_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.load) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cmd.push && status.last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: design/rrpg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rrpg_datapath import rrpg_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [NUM_W-1:0] cfg_wr_data,
  input  logic [VTX_W-1:0] round_number,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  output logic [VTX_W-1:0] low_vertex,
  output logic [VTX_W-1:0] high_vertex,
  output logic             last_pair,
  output logic             empty_round
);

  localparam logic [NUM_W-1:0] MAX_N = NUM_W'(MAX_VERTICES);

  logic [NUM_W-1:0] vertex_count;

  // round context
  logic [VTX_W-1:0] rnd;
  logic [VTX_W-1:0] m_val;      // n-1: circle size (even) or jump target (odd)
  logic             odd_mode;
  logic             first;
  logic             empty_flag;

  // current pair and pairs left
  logic [VTX_W-1:0] a;
  logic [VTX_W-1:0] b;
  logic [CNT_W-1:0] cnt;

  // set-up terms
  logic [NUM_W-1:0] n_m1;
  logic [NUM_W-1:0] r_ext;
  logic [VTX_W-1:0] total_m1;
  logic             too_few;
  logic             out_of_range;
  logic             load_empty;
  logic [VTX_W-1:0] load_a;
  logic [VTX_W-1:0] load_b;

  // step terms
  logic [NUM_W-1:0] a_p2;
  logic             jump;
  logic [VTX_W-1:0] m_m1;
  logic [VTX_W-1:0] dec_a;
  logic [VTX_W-1:0] inc_src;
  logic [VTX_W-1:0] inc_b;
  logic [VTX_W-1:0] a_next;
  logic [VTX_W-1:0] b_next;

  always_comb begin
    n_m1         = vertex_count - NUM_W'(1);
    r_ext        = {1'b0, round_number};
    total_m1     = vertex_count[NUM_W-1:1] - VTX_W'(1);
    too_few      = (vertex_count <= NUM_W'(1)) || (vertex_count > MAX_N);
    out_of_range = vertex_count[0] ? (r_ext >= vertex_count) : (r_ext >= n_m1);
    load_empty   = too_few || out_of_range;
    if (load_empty) begin
      load_a = '0;
      load_b = '0;
    end else if (vertex_count[0]) begin
      // odd: (0, r), or straight to (r+1, n-1) when round 0 has no low segment
      load_a = (round_number != '0) ? VTX_W'(0) : VTX_W'(1);
      load_b = (round_number != '0) ? round_number : n_m1[VTX_W-1:0];
    end else begin
      // even: the round's own vertex against the centre
      load_a = round_number;
      load_b = n_m1[VTX_W-1:0];
    end
  end

  always_comb begin
    a_p2    = {1'b0, a} + NUM_W'(2);
    jump    = a_p2 >= {1'b0, b};
    m_m1    = m_val - VTX_W'(1);
    dec_a   = (a == '0) ? m_m1 : a - VTX_W'(1);
    inc_src = first ? rnd : b;
    inc_b   = (inc_src == m_m1) ? VTX_W'(0) : inc_src + VTX_W'(1);
    if (odd_mode) begin
      a_next = jump ? rnd + VTX_W'(1) : a + VTX_W'(1);
      b_next = jump ? m_val : b - VTX_W'(1);
    end else begin
      a_next = dec_a;
      b_next = inc_b;
    end
  end

  assign status.last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= NUM_W'(2);
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rnd        <= round_number;
      m_val      <= n_m1[VTX_W-1:0];
      odd_mode   <= vertex_count[0];
      first      <= 1'b1;
      empty_flag <= load_empty;
      a          <= load_a;
      b          <= load_b;
      cnt        <= load_empty ? CNT_W'(0) : total_m1[CNT_W-1:0];
    end else if (cmd.push) begin
      first <= 1'b0;
      a     <= a_next;
      b     <= b_next;
      cnt   <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      low_vertex  <= (a < b) ? a : b;
      high_vertex <= (a < b) ? b : a;
      last_pair   <= status.last;
      empty_round <= empty_flag;
    end
  end

endmodule

`default_nettype wire

// File: design/round_robin_pairing_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Round-robin pairing generator (circle method). Write the participant count
// through cfg_wr_en/cfg_wr_data (reset value 2) while the block is idle, then
// send round numbers on the input channel; each round comes back as a burst of
// pairs, smaller vertex first, with last_pair on the final transfer. Odd counts
// n have rounds 0..n-1 and (n-1)/2 pairs (one vertex sits out); even counts have
// rounds 0..n-2 and n/2 pairs, the first always against vertex n-1. A round out
// of range, or a count below 2 or above MAX_VERTICES, gives one transfer with
// empty_round and last_pair set and both vertices zero. Once a round is taken,
// the single pair-stepping unit gives one pair per cycle while out_ready is
// held high; a stalled output holds the pair stepping.
// in_ready drops while a round is being stepped out and rises again as soon as
// the final pair sits in the output register, so the next round can be taken
// while that pair still waits for its transfer.

module round_robin_pairing_generator_core import rrpg_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [NUM_W-1:0] cfg_wr_data,
  // round request
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VTX_W-1:0] round_number,
  // pair results
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VTX_W-1:0] low_vertex,
  output logic [VTX_W-1:0] high_vertex,
  output logic             last_pair,
  output logic             empty_round
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: takes a round, then pushes one pair per free output slot
  rrpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // count register, pair stepping and the output register
  rrpg_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .round_number (round_number),
    .cmd          (cmd),
    .status       (status),
    .low_vertex   (low_vertex),
    .high_vertex  (high_vertex),
    .last_pair    (last_pair),
    .empty_round  (empty_round)
  );

endmodule

`default_nettype wire

// File: design/rrpg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rrpg_checker import rrpg_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VTX_W-1:0] low_vertex,
  input logic [VTX_W-1:0] high_vertex,
  input logic             last_pair,
  input logic             empty_round
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(low_vertex) &&
      $stable(high_vertex) && $stable(last_pair) && $stable(empty_round))
    else $error("stalled result changed");

  // an empty round is a single zero transfer
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_round |->
      last_pair && (low_vertex == '0) && (high_vertex == '0))
    else $error("empty round result malformed");

  // real pairs are ordered and distinct
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_round |-> low_vertex < high_vertex)
    else $error("pair not in ascending order");

  // a taken round blocks the input straight after its transfer
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a round transfer");

endmodule

bind round_robin_pairing_generator_core rrpg_checker u_rrpg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .low_vertex  (low_vertex),
  .high_vertex (high_vertex),
  .last_pair   (last_pair),
  .empty_round (empty_round)
);

`default_nettype wire
